>>> hdl/free_region_subtractor_defines.svh
// Assertion macros for the free region subtractor.
// Included by the top level; expects clk and rst_n in the including scope.
// With SYNTH defined the macros expand to nothing.
`ifndef FREE_REGION_SUBTRACTOR_DEFINES_SVH
`define FREE_REGION_SUBTRACTOR_DEFINES_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define FRS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("free_region_subtractor: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("free_region_subtractor: next-cycle check failed");

`else

`define FRS_ASSERT_IMPLY(lbl, ante, cons)
`define FRS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/frs_pkg.sv
// Shared types and constants for the free region subtractor.
// Used by the front end, the back end and the top level; depends on nothing.
`default_nettype none

package frs_pkg;

    // Field widths of addresses, sizes and exact range ends.
    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 49;
    localparam int END_W    = 50;
    localparam int ACTION_W = 2;

    // Default table depth.
    localparam int MAX_REGIONS_DEF = 16;

    // One past the highest address, as a size.
    localparam logic [SIZE_W-1:0] ADDR_TOP = {1'b1, {ADDR_W{1'b0}}};

    // Action codes carried on the input channel.
    localparam logic [ACTION_W-1:0] ACT_ADD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SUB  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

    // Command kinds after classification by the front end.
    localparam logic [1:0] KIND_NOP  = 2'd0;
    localparam logic [1:0] KIND_ADD  = 2'd1;
    localparam logic [1:0] KIND_SUB  = 2'd2;
    localparam logic [1:0] KIND_READ = 2'd3;

    // A classified command as it waits in the queue.
    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size;
        logic [END_W-1:0]  range_end;
    } frs_cmd_t;

    // One table row.
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size;
    } frs_region_t;

    // Status flags of a result, entry_valid in the lowest bit.
    typedef struct packed {
        logic add_rejected;
        logic split_dropped;
        logic entry_valid;
    } frs_flags_t;

endpackage

`default_nettype wire

>>> hdl/frs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module frs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/frs_front.sv
// Front end: accepts input transfers, classifies them and queues the commands.
// Depends on frs_pkg for the command type and the action codes.
`default_nettype none

module frs_front #(
    parameter int MAX_REGIONS = frs_pkg::MAX_REGIONS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [frs_pkg::ACTION_W-1:0]     in_action,
    input  wire logic [frs_pkg::ADDR_W-1:0]       in_base,
    input  wire logic [frs_pkg::SIZE_W-1:0]       in_size,
    input  wire logic [$clog2(MAX_REGIONS)-1:0]   in_index,
    output logic                                  cmd_valid,
    output frs_pkg::frs_cmd_t                     cmd,
    output logic      [$clog2(MAX_REGIONS)-1:0]   cmd_index,
    input  wire logic                             cmd_pop
);

    import frs_pkg::*;

    localparam int IDX_W = $clog2(MAX_REGIONS);

    frs_cmd_t          q_cmd_reg [2];
    logic [IDX_W-1:0]  q_idx_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        fill_reg, fill_next;

    frs_cmd_t          cmd_in;
    logic [SIZE_W-1:0] room;
    logic              push;

    // Classify the item and work out the exact end of its range.
    always_comb
    begin
        room             = ADDR_TOP - SIZE_W'(in_base);
        cmd_in.base      = in_base;
        cmd_in.size      = in_size;
        cmd_in.range_end = END_W'(in_base) + END_W'(in_size);
        case (in_action)
            ACT_ADD:
            begin
                cmd_in.kind = KIND_ADD;
                // A region may not reach past the top of the address space.
                if (in_size > room)
                begin
                    cmd_in.size = room;
                end
            end
            ACT_SUB:  cmd_in.kind = (in_size == '0) ? KIND_NOP : KIND_SUB;
            ACT_READ: cmd_in.kind = KIND_READ;
            default:  cmd_in.kind = KIND_NOP;
        endcase
    end

    // Two-entry command queue.
    assign in_ready  = (fill_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_cmd_reg[rd_ptr_reg];
    assign cmd_index = q_idx_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !cmd_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_cmd_reg[wr_ptr_reg] <= cmd_in;
            q_idx_reg[wr_ptr_reg] <= in_index;
        end
    end

endmodule

`default_nettype wire

>>> hdl/frs_back.sv
// Back end: carries out queued commands on the region table and holds the result register.
// Depends on frs_pkg and on frs_ram for the table and the store of split upper parts.
`default_nettype none

module frs_back #(
    parameter int MAX_REGIONS = frs_pkg::MAX_REGIONS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cmd_valid,
    input  wire frs_pkg::frs_cmd_t                     cmd,
    input  wire logic [$clog2(MAX_REGIONS)-1:0]        cmd_index,
    output logic                                       cmd_pop,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic      [$clog2(MAX_REGIONS+1)-1:0]      m_count,
    output logic      [frs_pkg::ADDR_W-1:0]            m_base,
    output logic      [frs_pkg::SIZE_W-1:0]            m_size,
    output frs_pkg::frs_flags_t                        m_flags
);

    import frs_pkg::*;

    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int ROW_W = $bits(frs_region_t);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_RD_WAIT   = 3'd1;
    localparam logic [2:0] ST_SCAN_RD   = 3'd2;
    localparam logic [2:0] ST_SCAN_EVAL = 3'd3;
    localparam logic [2:0] ST_SCAN_ACT  = 3'd4;
    localparam logic [2:0] ST_COPY_RD   = 3'd5;
    localparam logic [2:0] ST_COPY_WR   = 3'd6;
    localparam logic [2:0] ST_DONE      = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  wptr_reg, wptr_next;
    logic [CNT_W-1:0]  aptr_reg, aptr_next;
    logic [CNT_W-1:0]  cptr_reg, cptr_next;
    frs_cmd_t          cmd_reg, cmd_next;
    logic [ADDR_W-1:0] cur_base_reg, cur_base_next;
    logic [SIZE_W-1:0] cur_size_reg, cur_size_next;
    logic [END_W-1:0]  cur_end_reg, cur_end_next;
    logic [ADDR_W-1:0] res_base_reg, res_base_next;
    logic [SIZE_W-1:0] res_size_reg, res_size_next;
    frs_flags_t        res_flags_reg, res_flags_next;
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;
    logic [ADDR_W-1:0] out_base_reg, out_base_next;
    logic [SIZE_W-1:0] out_size_reg, out_size_next;
    frs_flags_t        out_flags_reg, out_flags_next;

    // Table and split store ports.
    logic              tab_we, tab_re, app_we, app_re;
    logic [IDX_W-1:0]  tab_waddr, tab_raddr, app_waddr, app_raddr;
    frs_region_t       tab_wdata, app_wdata;
    logic [ROW_W-1:0]  tab_rdata, app_rdata;
    frs_region_t       tab_row, app_row;

    // Overlap decision terms.
    logic [END_W-1:0]  rng_lo, cur_lo, lo_part, hi_part;
    logic              no_overlap, hit_start, hit_end;
    logic [CNT_W:0]    live_count;
    logic [CNT_W-1:0]  rptr_inc, cptr_inc;

    frs_ram #(
        .WIDTH(ROW_W),
        .DEPTH(MAX_REGIONS)
    ) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .re    (tab_re),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    frs_ram #(
        .WIDTH(ROW_W),
        .DEPTH(MAX_REGIONS)
    ) u_split_store (
        .clk   (clk),
        .we    (app_we),
        .waddr (app_waddr),
        .wdata (app_wdata),
        .re    (app_re),
        .raddr (app_raddr),
        .rdata (app_rdata)
    );

    assign tab_row = tab_rdata;
    assign app_row = app_rdata;

    // Compare the current entry against the reserved range.
    always_comb
    begin
        rng_lo     = END_W'(cmd_reg.base);
        cur_lo     = END_W'(cur_base_reg);
        no_overlap = (cur_end_reg <= rng_lo) || (cmd_reg.range_end <= cur_lo);
        hit_start  = (rng_lo <= cur_lo);
        hit_end    = (cmd_reg.range_end >= cur_end_reg);
        lo_part    = rng_lo - cur_lo;
        hi_part    = cur_end_reg - cmd_reg.range_end;
        // Entries the table would hold now, the current one included.
        live_count = (CNT_W+1)'(wptr_reg) + (CNT_W+1)'(count_reg) - (CNT_W+1)'(rptr_reg)
                   + (CNT_W+1)'(aptr_reg);
        rptr_inc   = rptr_reg + ONE;
        cptr_inc   = cptr_reg + ONE;
    end

    assign cmd_pop = (state_reg == ST_IDLE) && cmd_valid;

    // Command sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rptr_next      = rptr_reg;
        wptr_next      = wptr_reg;
        aptr_next      = aptr_reg;
        cptr_next      = cptr_reg;
        cmd_next       = cmd_reg;
        cur_base_next  = cur_base_reg;
        cur_size_next  = cur_size_reg;
        cur_end_next   = cur_end_reg;
        res_base_next  = res_base_reg;
        res_size_next  = res_size_reg;
        res_flags_next = res_flags_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_base_next  = out_base_reg;
        out_size_next  = out_size_reg;
        out_flags_next = out_flags_reg;
        tab_we         = 1'b0;
        tab_waddr      = wptr_reg[IDX_W-1:0];
        tab_wdata      = '{base: cur_base_reg, size: cur_size_reg};
        tab_re         = 1'b0;
        tab_raddr      = rptr_reg[IDX_W-1:0];
        app_we         = 1'b0;
        app_waddr      = aptr_reg[IDX_W-1:0];
        app_wdata      = '{base: cmd_reg.range_end[ADDR_W-1:0], size: hi_part[SIZE_W-1:0]};
        app_re         = 1'b0;
        app_raddr      = cptr_reg[IDX_W-1:0];

        // The result register empties when its transfer completes.
        if (out_valid_reg && m_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next       = cmd;
                    res_base_next  = '0;
                    res_size_next  = '0;
                    res_flags_next = '0;
                    rptr_next      = '0;
                    wptr_next      = '0;
                    aptr_next      = '0;
                    state_next     = ST_DONE;
                    case (cmd.kind)
                        KIND_ADD:
                        begin
                            if (count_reg < MAX_CNT)
                            begin
                                tab_we     = 1'b1;
                                tab_waddr  = count_reg[IDX_W-1:0];
                                tab_wdata  = '{base: cmd.base, size: cmd.size};
                                count_next = count_reg + ONE;
                            end
                            else
                            begin
                                res_flags_next.add_rejected = 1'b1;
                            end
                        end
                        KIND_SUB:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ST_SCAN_RD;
                            end
                        end
                        KIND_READ:
                        begin
                            if (CNT_W'(cmd_index) < count_reg)
                            begin
                                tab_re     = 1'b1;
                                tab_raddr  = cmd_index;
                                state_next = ST_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_RD_WAIT:
            begin
                res_base_next              = tab_row.base;
                res_size_next              = tab_row.size;
                res_flags_next.entry_valid = 1'b1;
                state_next                 = ST_DONE;
            end

            ST_SCAN_RD:
            begin
                tab_re     = 1'b1;
                state_next = ST_SCAN_EVAL;
            end

            ST_SCAN_EVAL:
            begin
                cur_base_next = tab_row.base;
                cur_size_next = tab_row.size;
                cur_end_next  = END_W'(tab_row.base) + END_W'(tab_row.size);
                state_next    = ST_SCAN_ACT;
            end

            ST_SCAN_ACT:
            begin
                // Keep, trim or split the entry; a fully covered one is not written back.
                if (no_overlap)
                begin
                    tab_we    = 1'b1;
                    wptr_next = wptr_reg + ONE;
                end
                else if (hit_start && !hit_end)
                begin
                    tab_we    = 1'b1;
                    tab_wdata = '{base: cmd_reg.range_end[ADDR_W-1:0],
                                  size: hi_part[SIZE_W-1:0]};
                    wptr_next = wptr_reg + ONE;
                end
                else if (!hit_start)
                begin
                    tab_we    = 1'b1;
                    tab_wdata = '{base: cur_base_reg, size: lo_part[SIZE_W-1:0]};
                    wptr_next = wptr_reg + ONE;
                    // A middle hit leaves an upper part for the end of the table.
                    if (!hit_end)
                    begin
                        if (live_count < (CNT_W+1)'(MAX_REGIONS))
                        begin
                            app_we    = 1'b1;
                            aptr_next = aptr_reg + ONE;
                        end
                        else
                        begin
                            res_flags_next.split_dropped = 1'b1;
                        end
                    end
                end

                rptr_next = rptr_inc;
                if (rptr_inc < count_reg)
                begin
                    tab_re     = 1'b1;
                    tab_raddr  = rptr_inc[IDX_W-1:0];
                    state_next = ST_SCAN_EVAL;
                end
                else if (aptr_next != '0)
                begin
                    cptr_next  = '0;
                    state_next = ST_COPY_RD;
                end
                else
                begin
                    count_next = wptr_next;
                    state_next = ST_DONE;
                end
            end

            ST_COPY_RD:
            begin
                app_re     = 1'b1;
                state_next = ST_COPY_WR;
            end

            ST_COPY_WR:
            begin
                // Move the split upper parts behind the compacted entries.
                tab_we    = 1'b1;
                tab_wdata = app_row;
                wptr_next = wptr_reg + ONE;
                cptr_next = cptr_inc;
                if (cptr_inc < aptr_reg)
                begin
                    app_re    = 1'b1;
                    app_raddr = cptr_inc[IDX_W-1:0];
                end
                else
                begin
                    count_next = wptr_reg + ONE;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    out_base_next  = res_base_reg;
                    out_size_next  = res_size_reg;
                    out_flags_next = res_flags_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pointers and payload.
    always_ff @(posedge clk)
    begin
        rptr_reg      <= rptr_next;
        wptr_reg      <= wptr_next;
        aptr_reg      <= aptr_next;
        cptr_reg      <= cptr_next;
        cmd_reg       <= cmd_next;
        cur_base_reg  <= cur_base_next;
        cur_size_reg  <= cur_size_next;
        cur_end_reg   <= cur_end_next;
        res_base_reg  <= res_base_next;
        res_size_reg  <= res_size_next;
        res_flags_reg <= res_flags_next;
        out_count_reg <= out_count_next;
        out_base_reg  <= out_base_next;
        out_size_reg  <= out_size_next;
        out_flags_reg <= out_flags_next;
    end

    assign m_valid = out_valid_reg;
    assign m_count = out_count_reg;
    assign m_base  = out_base_reg;
    assign m_size  = out_size_reg;
    assign m_flags = out_flags_reg;

endmodule

`default_nettype wire

>>> hdl/free_region_subtractor.sv
// Top level of the free region subtractor: front end, command queue and back end.
// Depends on frs_pkg, frs_front, frs_back (with frs_ram) and the assertion macro header.
//
// Usage:
//   Input stream (s_axis_*): one command per transfer. tuser carries the action
//   (add region, subtract reserved range, read entry); tdata carries the range
//   base, range size and entry index.
//   Output stream (m_axis_*): exactly one result per command, in order: the
//   region count, the entry read (zero unless a read hit a valid slot) and the
//   status flags.
//   Sequencing: commands run one at a time. A subtract reads and evaluates each
//   table entry in turn, writing back the kept or trimmed parts, and then moves
//   the split upper parts to the end of the table one by one.
//   A two-entry queue in front lets new commands be taken while the back end is
//   busy or a result waits. While m_axis_tready is low the result register holds
//   and the back end waits before starting on the next command.
//   Reset clears the region count, the queue and the result register; table
//   contents need no clearing as only entries below the count are ever read.
`default_nettype none
`include "free_region_subtractor_defines.svh"

module free_region_subtractor #(
    parameter int MAX_REGIONS = frs_pkg::MAX_REGIONS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // Fields from bit 0: range_base[47:0], range_size[48:0], entry_index, zero padding.
    input  wire logic [((frs_pkg::ADDR_W + frs_pkg::SIZE_W + $clog2(MAX_REGIONS) + 7) / 8) * 8 - 1:0]
                      s_axis_tdata,
    // Fields from bit 0: action[1:0].
    input  wire logic [frs_pkg::ACTION_W-1:0] s_axis_tuser,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // Fields from bit 0: region_count, entry_base[47:0], entry_size[48:0], zero padding.
    output logic [(($clog2(MAX_REGIONS + 1) + frs_pkg::ADDR_W + frs_pkg::SIZE_W + 7) / 8) * 8 - 1:0]
                      m_axis_tdata,
    // Fields from bit 0: entry_valid, split_dropped, add_rejected.
    output logic [$bits(frs_pkg::frs_flags_t)-1:0] m_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready
);

    import frs_pkg::*;

    localparam int IDX_W      = $clog2(MAX_REGIONS);
    localparam int CNT_W      = $clog2(MAX_REGIONS + 1);
    localparam int OUT_DATA_W = ((CNT_W + ADDR_W + SIZE_W + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

    logic              cmd_valid;
    logic              cmd_pop;
    frs_cmd_t          cmd;
    logic [IDX_W-1:0]  cmd_index;
    logic [CNT_W-1:0]  res_count;
    logic [ADDR_W-1:0] res_base;
    logic [SIZE_W-1:0] res_size;
    frs_flags_t        res_flags;

    // Front end with the command queue.
    frs_front #(
        .MAX_REGIONS(MAX_REGIONS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_base   (s_axis_tdata[ADDR_W-1:0]),
        .in_size   (s_axis_tdata[ADDR_W+SIZE_W-1:ADDR_W]),
        .in_index  (s_axis_tdata[ADDR_W+SIZE_W+IDX_W-1:ADDR_W+SIZE_W]),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_index (cmd_index),
        .cmd_pop   (cmd_pop)
    );

    // Back end with the region table and the result register.
    frs_back #(
        .MAX_REGIONS(MAX_REGIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_index (cmd_index),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_count   (res_count),
        .m_base    (res_base),
        .m_size    (res_size),
        .m_flags   (res_flags)
    );

    // Pack the result fields.
    assign m_axis_tdata = OUT_DATA_W'({res_size, res_base, res_count});
    assign m_axis_tuser = res_flags;

    // The back end takes a command only when one is queued.
    `FRS_ASSERT_IMPLY(a_pop_needs_cmd, cmd_pop, cmd_valid)
    // One command at a time: a pop is never followed by another in the next cycle.
    `FRS_ASSERT_NEXT(a_single_pop, cmd_pop, !cmd_pop)
    // The reported count never exceeds the table depth.
    `FRS_ASSERT_IMPLY(a_count_bound, m_axis_tvalid, res_count <= MAX_CNT)
    // At most one status flag per result.
    `FRS_ASSERT_IMPLY(a_one_flag, m_axis_tvalid, $countones(m_axis_tuser) <= 1)
    // A rejected add is only reported on a full table.
    `FRS_ASSERT_IMPLY(a_reject_full, m_axis_tvalid && res_flags.add_rejected,
                      res_count == MAX_CNT)

endmodule

`default_nettype wire
